// File: hw/rtl/assert_macros.svh
// Assertion macros used by automaton_word_count_mod.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define ACWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: cause holds, then effect holds in the same cycle.
`define ACWC_ASSERT_IMP(label, cause, effect, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |-> (effect)) \
    else $error(msg);

`endif

// File: hw/rtl/acwc_pkg.sv
// Shared types, constants and modular helpers of the automaton word counter.
package acwc_pkg;

  localparam int MAX_STATES_DEF  = 64;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CNT_WIDTH       = 30;
  localparam int STATE_WIDTH     = 6;
  localparam int ACTION_WIDTH    = 2;
  localparam int WLEN_WIDTH      = 16;
  localparam int STATE_EXT_WIDTH = 11;

  localparam logic [CNT_WIDTH-1:0] PRIME = 30'd1000000007;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_ADD  = 2'd0,
    ACT_MARK = 2'd1,
    ACT_RUN  = 2'd2
  } action_e;

  typedef struct packed {
    logic                 start;
    logic [CNT_WIDTH-1:0] a;
  } mul_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [CNT_WIDTH-1:0] prod;
  } mul_rsp_t;

  // (a + b) mod PRIME for a, b < PRIME
  function automatic logic [CNT_WIDTH-1:0] add_mod(input logic [CNT_WIDTH-1:0] a,
                                                  input logic [CNT_WIDTH-1:0] b);
    logic [CNT_WIDTH:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, PRIME}) begin
      sum = sum - {1'b0, PRIME};
    end
    return sum[CNT_WIDTH-1:0];
  endfunction

endpackage

// File: hw/rtl/automaton_word_count_mod.sv
// Automaton word counter top level: sequencer around edge, flag and path count RAMs.
// After reset the block sweeps the whole edge RAM to clear it, with ready low. An
// add-transition word does a read, modify and write of its edge entry; a mark word
// sets the flag of its state. A run word first seeds the path counts, then for each
// letter walks every edge entry, using the bit-serial multiplier for every entry
// whose edge count and path count are both nonzero, then forms the final sum and
// hands the result to the output register. The letter loop stops early once all
// counts are zero. One word is processed at a time; the result waits in the output
// register.
`include "assert_macros.svh"

module automaton_word_count_mod #(
  parameter int MAX_STATES  = acwc_pkg::MAX_STATES_DEF,
  parameter int COUNT_WIDTH = acwc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [acwc_pkg::WLEN_WIDTH-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [acwc_pkg::ACTION_WIDTH-1:0]  action_i,
  input  logic [acwc_pkg::STATE_WIDTH-1:0]   from_state_i,
  input  logic [acwc_pkg::STATE_WIDTH-1:0]   to_state_i,
  input  logic [acwc_pkg::STATE_WIDTH-1:0]   accept_state_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [acwc_pkg::CNT_WIDTH-1:0]     word_count_o
);
  import acwc_pkg::*;

  localparam int EDGES = MAX_STATES * MAX_STATES;
  localparam int IW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int EW    = (EDGES > 1) ? $clog2(EDGES) : 1;

  typedef enum logic [11:0] {
    ST_CLEAR    = 12'b0000_0000_0001,
    ST_IDLE     = 12'b0000_0000_0010,
    ST_ADD_RD   = 12'b0000_0000_0100,
    ST_ADD_WR   = 12'b0000_0000_1000,
    ST_INIT     = 12'b0000_0001_0000,
    ST_STEP_RD  = 12'b0000_0010_0000,
    ST_STEP_LD  = 12'b0000_0100_0000,
    ST_STEP_MUL = 12'b0000_1000_0000,
    ST_STEP_NX  = 12'b0001_0000_0000,
    ST_SUM_RD   = 12'b0010_0000_0000,
    ST_SUM_AC   = 12'b0100_0000_0000,
    ST_DONE     = 12'b1000_0000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [WLEN_WIDTH-1:0] wlen_q;
  logic [EW-1:0]         clr_q, clr_d;
  logic [EW-1:0]         eaddr_q, eaddr_d;
  logic [IW-1:0]         s_q, s_d, t_q, t_d;
  logic [WLEN_WIDTH-1:0] step_q, step_d;
  logic                  cur_q, cur_d;
  logic                  any_q, any_d;
  logic [CNT_WIDTH-1:0]  acc_q, acc_d, tot_q, tot_d;
  logic                  out_valid_q, out_valid_d;
  logic [CNT_WIDTH-1:0]  out_q, out_d;

  logic                       e_we, f_we, p_we, f_wdata;
  logic [EW-1:0]              e_waddr, e_raddr;
  logic [COUNT_WIDTH-1:0]     e_wdata, e_rdata;
  logic [IW-1:0]              f_waddr;
  logic                       f_rdata;
  logic [IW:0]                p_waddr, p_raddr;
  logic [CNT_WIDTH-1:0]       p_wdata, p_rdata;
  mul_req_t                   mreq;
  mul_rsp_t                   mrsp;

  logic [STATE_EXT_WIDTH-1:0] from_ext, to_ext, accs_ext;
  logic                       s_last, t_last, in_acc;
  logic [CNT_WIDTH-1:0]       acc_fin;

  assign from_ext = STATE_EXT_WIDTH'(from_state_i);
  assign to_ext   = STATE_EXT_WIDTH'(to_state_i);
  assign accs_ext = STATE_EXT_WIDTH'(accept_state_i);
  assign s_last   = (s_q == IW'(MAX_STATES - 1));
  assign t_last   = (t_q == IW'(MAX_STATES - 1));
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc   = in_valid_i && in_ready_o;
  assign acc_fin  = mrsp.done ? add_mod(acc_q, mrsp.prod) : acc_q;

  acwc_ram #(.WIDTH(COUNT_WIDTH), .ADDR_WIDTH(EW)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  acwc_ram #(.WIDTH(1), .ADDR_WIDTH(IW)) u_flag_ram (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(s_q), .rdata_o(f_rdata)
  );

  acwc_ram #(.WIDTH(CNT_WIDTH), .ADDR_WIDTH(IW + 1)) u_path_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  acwc_modmul #(.COUNT_WIDTH(COUNT_WIDTH)) u_modmul (
    .clk_i, .rst_ni, .req_i(mreq), .m_i(e_rdata), .rsp_o(mrsp)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    eaddr_d     = eaddr_q;
    s_d         = s_q;
    t_d         = t_q;
    step_d      = step_q;
    cur_d       = cur_q;
    any_d       = any_q;
    acc_d       = acc_q;
    tot_d       = tot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    e_we    = 1'b0;
    e_waddr = eaddr_q;
    e_wdata = '0;
    e_raddr = eaddr_q;
    f_we    = 1'b0;
    f_waddr = accs_ext[IW-1:0];
    f_wdata = 1'b1;
    p_we    = 1'b0;
    p_waddr = {cur_q, s_q};
    p_wdata = '0;
    p_raddr = {cur_q, s_q};
    mreq.start = 1'b0;
    mreq.a     = p_rdata;

    unique case (state_q)
      ST_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = clr_q;
        e_wdata = '0;
        if (clr_q < EW'(MAX_STATES)) begin
          f_we    = 1'b1;
          f_waddr = clr_q[IW-1:0];
          f_wdata = 1'b0;
        end
        clr_d = clr_q + EW'(1);
        if (clr_q == EW'(EDGES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_e'(action_i))
            ACT_ADD: begin
              if (from_ext < STATE_EXT_WIDTH'(MAX_STATES)
                  && to_ext < STATE_EXT_WIDTH'(MAX_STATES)) begin
                eaddr_d = EW'(from_ext) * EW'(MAX_STATES) + EW'(to_ext);
                state_d = ST_ADD_RD;
              end
            end
            ACT_MARK: begin
              if (accs_ext < STATE_EXT_WIDTH'(MAX_STATES)) begin
                f_we = 1'b1;
              end
            end
            ACT_RUN: begin
              s_d     = '0;
              state_d = ST_INIT;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_RD: begin
        state_d = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        e_we    = 1'b1;
        e_wdata = (e_rdata == '1) ? e_rdata : e_rdata + COUNT_WIDTH'(1);
        state_d = ST_IDLE;
      end
      ST_INIT: begin
        p_we    = 1'b1;
        p_wdata = (s_q == '0) ? CNT_WIDTH'(1) : '0;
        s_d     = s_q + IW'(1);
        if (s_last) begin
          s_d     = '0;
          t_d     = '0;
          eaddr_d = '0;
          step_d  = '0;
          acc_d   = '0;
          any_d   = 1'b0;
          tot_d   = '0;
          state_d = (wlen_q == '0) ? ST_SUM_RD : ST_STEP_RD;
        end
      end
      ST_STEP_RD: begin
        state_d = ST_STEP_LD;
      end
      ST_STEP_LD: begin
        if (e_rdata != '0 && p_rdata != '0) begin
          mreq.start = 1'b1;
          state_d    = ST_STEP_MUL;
        end else begin
          state_d = ST_STEP_NX;
        end
      end
      ST_STEP_MUL: begin
        if (mrsp.done) begin
          acc_d   = acc_fin;
          state_d = ST_STEP_NX;
        end
      end
      ST_STEP_NX: begin
        state_d = ST_STEP_RD;
        if (s_last) begin
          p_we    = 1'b1;
          p_waddr = {~cur_q, t_q};
          p_wdata = acc_q;
          acc_d   = '0;
          s_d     = '0;
          any_d   = any_q || (acc_q != '0);
          if (t_last) begin
            t_d     = '0;
            eaddr_d = '0;
            cur_d   = ~cur_q;
            step_d  = step_q + WLEN_WIDTH'(1);
            any_d   = 1'b0;
            if ((step_q + WLEN_WIDTH'(1) == wlen_q) || !(any_q || (acc_q != '0))) begin
              state_d = ST_SUM_RD;
            end
          end else begin
            t_d     = t_q + IW'(1);
            eaddr_d = EW'(t_q) + EW'(1);
          end
        end else begin
          s_d     = s_q + IW'(1);
          eaddr_d = eaddr_q + EW'(MAX_STATES);
        end
      end
      ST_SUM_RD: begin
        state_d = ST_SUM_AC;
      end
      ST_SUM_AC: begin
        if (f_rdata) begin
          tot_d = add_mod(tot_q, p_rdata);
        end
        s_d     = s_q + IW'(1);
        state_d = ST_SUM_RD;
        if (s_last) begin
          s_d     = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = tot_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      wlen_q      <= '0;
      clr_q       <= '0;
      s_q         <= '0;
      t_q         <= '0;
      step_q      <= '0;
      cur_q       <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      s_q         <= s_d;
      t_q         <= t_d;
      step_q      <= step_d;
      cur_q       <= cur_d;
      any_q       <= any_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eaddr_q <= eaddr_d;
    acc_q   <= acc_d;
    tot_q   <= tot_d;
    out_q   <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign word_count_o = out_q;

  `ACWC_ASSERT_IMP(a_mul_in_step, mrsp.busy, state_q == ST_STEP_MUL, "multiplier busy outside step")
  `ACWC_ASSERT_IMP(a_acc_range, state_q == ST_STEP_NX, acc_q < PRIME, "row sum not reduced")
  `ACWC_ASSERT_IMP(a_tot_range, state_q == ST_DONE, tot_q < PRIME, "total not reduced")
  `ACWC_ASSERT(a_out_src, $rose(out_valid_o) |-> $past(state_q == ST_DONE), "result without run")

endmodule

// File: hw/rtl/acwc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module acwc_ram #(
  parameter int WIDTH      = 8,
  parameter int ADDR_WIDTH = 4
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_WIDTH-1:0] waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic [ADDR_WIDTH-1:0] raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_WIDTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/acwc_modmul.sv
// Bit-serial modular multiplier: count times multiplicity mod the prime.
module acwc_modmul #(
  parameter int COUNT_WIDTH = acwc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  acwc_pkg::mul_req_t       req_i,
  input  logic [COUNT_WIDTH-1:0]   m_i,
  output acwc_pkg::mul_rsp_t       rsp_o
);
  import acwc_pkg::*;

  localparam int CW = $clog2(COUNT_WIDTH + 1);

  logic                   busy_q, busy_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] m_q, m_d;
  logic [CNT_WIDTH-1:0]   a_q, a_d;
  logic [CNT_WIDTH-1:0]   r_q, r_d;
  logic [CNT_WIDTH-1:0]   r_dbl, r_nxt;

  // MSB first: r = 2r (+ a)
  always_comb begin
    r_dbl = add_mod(r_q, r_q);
    r_nxt = m_q[COUNT_WIDTH-1] ? add_mod(r_dbl, a_q) : r_dbl;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    m_d    = m_q;
    a_d    = a_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(COUNT_WIDTH);
      m_d    = m_i;
      a_d    = req_i.a;
      r_d    = '0;
    end else if (busy_q) begin
      r_d   = r_nxt;
      m_d   = m_q << 1;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    a_q <= a_d;
    r_q <= r_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = busy_q && (cnt_q == CW'(1));
  assign rsp_o.prod = r_nxt;

endmodule
